/* sv/dbrf_pkg.sv */
package dbrf_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_CONF_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_MODE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_X         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_Y         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd7;

   localparam logic [15:0] CONF_THRESHOLD_RST = 16'd32768;
   localparam logic [31:0] GAIN_RST = 32'd65536;

   typedef struct packed {
      logic [15:0] conf_thresh;
      logic        format_mode;
      logic [31:0] gain_x;
      logic [31:0] gain_y;
      logic [31:0] offset_x;
      logic [31:0] offset_y;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } cfg_type;

   // candidate record handed from front to back
   typedef struct packed {
      logic [15:0]        label_id;
      logic [15:0]        confidence;
      logic signed [31:0] box_left;
      logic signed [31:0] box_top;
      logic signed [31:0] box_right;
      logic signed [31:0] box_bottom;
   } rec_type;

endpackage

/* sv/dbrf_ifs.sv */
interface dbrf_req_if;
   logic               valid;
   logic               ready;
   logic               end_marker;
   logic [15:0]        label_id;
   logic [15:0]        confidence;
   logic signed [31:0] box_left;
   logic signed [31:0] box_top;
   logic signed [31:0] box_right;
   logic signed [31:0] box_bottom;
   logic               last_record;

   modport source (
      output valid, end_marker, label_id, confidence,
      output box_left, box_top, box_right, box_bottom, last_record,
      input  ready
   );
   modport sink (
      input  valid, end_marker, label_id, confidence,
      input  box_left, box_top, box_right, box_bottom, last_record,
      output ready
   );
endinterface

interface dbrf_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        out_label;
   logic [15:0]        out_confidence;
   logic [15:0]        out_x;
   logic [15:0]        out_y;
   logic signed [16:0] out_width;
   logic signed [16:0] out_height;

   modport source (
      output valid, out_label, out_confidence, out_x, out_y, out_width, out_height,
      input  ready
   );
   modport sink (
      input  valid, out_label, out_confidence, out_x, out_y, out_width, out_height,
      output ready
   );
endinterface

interface dbrf_csr_if import dbrf_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/detection_box_rescale_filter_core.sv */
// Detection box rescale and filter.
// req: one detector record per word (end marker, label, confidence, four
//   signed corners, last-record flag). Records at or below the confidence
//   threshold, and records silenced by an end marker in single-tensor mode,
//   are taken one a cycle while the queue has room and give no word on rsp.
// rsp: one word per kept detection: label, confidence, clamped left/top
//   corner in pixels, signed width and height.
// csr: write-only register port, always ready; write only while idle.
// Timing: the front classifies a record in the cycle it is taken and pushes
//   candidates into a two-entry queue. The back pops one candidate, then
//   runs the four corners through one shared 31x32 multiplier, an offset
//   subtract and a round/clamp stage, seven steps in all, and registers the
//   result for rsp. The back takes no new candidate until it is through with
//   the last one; other records go at one a cycle while the queue has room.
// Reset clears the queue, the back and the frame stop flag, and loads the
//   register defaults. When rsp stalls the result holds in the output
//   register, the back waits, and req stalls once the queue is full.
module detection_box_rescale_filter_core import dbrf_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dbrf_req_if.sink   req,
   dbrf_rsp_if.source rsp,
   dbrf_csr_if.sink   csr
);

   cfg_type cfg_ff;
   logic    push_valid;
   logic    push_ready;
   rec_type push_rec;
   logic    pop_valid;
   logic    pop_ready;
   rec_type pop_rec;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_thresh <= CONF_THRESHOLD_RST;
         cfg_ff.format_mode <= 1'b0;
         cfg_ff.gain_x <= GAIN_RST;
         cfg_ff.gain_y <= GAIN_RST;
         cfg_ff.offset_x <= '0;
         cfg_ff.offset_y <= '0;
         cfg_ff.image_width <= '0;
         cfg_ff.image_height <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_CONF_THRESHOLD: cfg_ff.conf_thresh <= csr.data[15:0];
            CSR_FORMAT_MODE:    cfg_ff.format_mode <= csr.data[0];
            CSR_GAIN_X:         cfg_ff.gain_x <= csr.data;
            CSR_GAIN_Y:         cfg_ff.gain_y <= csr.data;
            CSR_OFFSET_X:       cfg_ff.offset_x <= csr.data;
            CSR_OFFSET_Y:       cfg_ff.offset_y <= csr.data;
            CSR_IMAGE_WIDTH:    cfg_ff.image_width <= csr.data[15:0];
            CSR_IMAGE_HEIGHT:   cfg_ff.image_height <= csr.data[15:0];
            default: ;
         endcase
      end
   end

   dbrf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec)
   );

   dbrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   dbrf_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_rec   (pop_rec),
      .rsp       (rsp)
   );

endmodule

/* sv/dbrf_front.sv */
module dbrf_front import dbrf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dbrf_req_if.sink   req,
   input  cfg_type    cfg,
   output logic       push_valid,
   input  logic       push_ready,
   output rec_type    push_rec
);

   logic stopped_ff;
   logic stopped_in;
   logic stop_now;
   logic candidate;
   logic accept;

   assign req.ready = push_ready;
   assign accept = req.valid && push_ready;

   // marker silences its own record in single-tensor mode
   assign stop_now = stopped_ff || (!cfg.format_mode && req.end_marker);
   assign candidate = (cfg.format_mode || !stop_now) &&
                      (req.confidence > cfg.conf_thresh);
   assign stopped_in = req.last_record ? 1'b0 : stop_now;

   assign push_valid = req.valid && candidate;
   assign push_rec.label_id = req.label_id;
   assign push_rec.confidence = req.confidence;
   assign push_rec.box_left = req.box_left;
   assign push_rec.box_top = req.box_top;
   assign push_rec.box_right = req.box_right;
   assign push_rec.box_bottom = req.box_bottom;

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else if (accept) begin
         stopped_ff <= stopped_in;
      end
   end

endmodule

/* sv/dbrf_queue.sv */
module dbrf_queue import dbrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  rec_type push_rec,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rec_type pop_rec
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_rec = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* sv/dbrf_back.sv */
module dbrf_back import dbrf_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  rec_type    pop_rec,
   dbrf_rsp_if.source rsp
);

   localparam int SHIFT = COORD_FRAC_BITS + 16;
   localparam int PROD_W = 63;
   localparam int SUM_W = PROD_W + 1;
   localparam int RND_W = SUM_W - SHIFT;

   // step 0..3 multiply corner, 1..4 subtract offset, 2..5 round and clamp, 6 finish
   localparam logic [2:0] STEP_MUL_LAST = 3'd3;
   localparam logic [2:0] STEP_RND_FIRST = 3'd2;
   localparam logic [2:0] STEP_RND_LAST = 3'd5;
   localparam logic [2:0] STEP_LAST = 3'd6;

   rec_type            rec_ff;
   logic               busy_ff;
   logic [2:0]         step_ff;

   logic signed [31:0] coord_sel;
   logic [31:0]        gain_sel;
   logic [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]  prod_ff;
   logic               pos_ff;

   logic [PROD_W-1:0]  off_sel;
   logic [PROD_W-1:0]  diff_ff;
   logic               zero_ff;

   logic [1:0]         corner_idx;
   logic [SUM_W-1:0]   sum_rnd;
   logic [RND_W-1:0]   rnd;
   logic [15:0]        limit_sel;
   logic [15:0]        corner_in;
   logic [15:0]        corner_ff [4];

   logic signed [16:0] w_in;
   logic signed [16:0] h_in;
   logic               keep;
   logic               out_free;

   logic               out_valid_ff;
   logic [15:0]        out_label_ff;
   logic [15:0]        out_conf_ff;
   logic [15:0]        out_x_ff;
   logic [15:0]        out_y_ff;
   logic signed [16:0] out_w_ff;
   logic signed [16:0] out_h_ff;

   assign pop_ready = !busy_ff;

   // multiply stage: corners in order left, top, right, bottom
   always_comb begin
      case (step_ff[1:0])
         2'd0:    coord_sel = rec_ff.box_left;
         2'd1:    coord_sel = rec_ff.box_top;
         2'd2:    coord_sel = rec_ff.box_right;
         default: coord_sel = rec_ff.box_bottom;
      endcase
   end
   assign gain_sel = step_ff[0] ? cfg.gain_y : cfg.gain_x;
   assign prod_in = PROD_W'(coord_sel[30:0]) * PROD_W'(gain_sel);

   // subtract stage works on the corner one step behind
   assign off_sel = PROD_W'(step_ff[0] ? cfg.offset_x : cfg.offset_y) << COORD_FRAC_BITS;

   // round stage, two steps behind
   assign corner_idx = 2'(step_ff - STEP_RND_FIRST);
   assign limit_sel = corner_idx[0] ? cfg.image_height : cfg.image_width;
   assign sum_rnd = {1'b0, diff_ff} + (SUM_W'(1) << (SHIFT - 1));
   assign rnd = sum_rnd[SUM_W-1:SHIFT];

   always_comb begin
      if (zero_ff) begin
         corner_in = '0;
      end else if ((|rnd[RND_W-1:16]) || (rnd[15:0] > limit_sel)) begin
         corner_in = limit_sel;
      end else begin
         corner_in = rnd[15:0];
      end
   end

   assign w_in = $signed({1'b0, corner_ff[2]}) - $signed({1'b0, corner_ff[0]});
   assign h_in = $signed({1'b0, corner_ff[3]}) - $signed({1'b0, corner_ff[1]});
   // w * h >= 1 exactly when both are nonzero and share a sign
   assign keep = !cfg.format_mode ||
                 ((w_in != '0) && (h_in != '0) && (w_in[16] == h_in[16]));
   assign out_free = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (busy_ff && (step_ff == STEP_LAST) && keep && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (!busy_ff) begin
            if (pop_valid) begin
               busy_ff <= 1'b1;
               step_ff <= '0;
            end
         end else if (step_ff != STEP_LAST) begin
            step_ff <= step_ff + 1'b1;
         end else if (!keep || out_free) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && pop_valid) begin
         rec_ff <= pop_rec;
      end
      if (step_ff <= STEP_MUL_LAST) begin
         prod_ff <= prod_in;
         pos_ff <= !coord_sel[31] && (coord_sel != '0);
      end
      zero_ff <= !pos_ff || (prod_ff <= off_sel);
      diff_ff <= prod_ff - off_sel;
      if (busy_ff && (step_ff >= STEP_RND_FIRST) && (step_ff <= STEP_RND_LAST)) begin
         corner_ff[corner_idx] <= corner_in;
      end
      if (busy_ff && (step_ff == STEP_LAST) && keep && out_free) begin
         out_label_ff <= rec_ff.label_id;
         out_conf_ff <= rec_ff.confidence;
         out_x_ff <= corner_ff[0];
         out_y_ff <= corner_ff[1];
         out_w_ff <= w_in;
         out_h_ff <= h_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_label = out_label_ff;
   assign rsp.out_confidence = out_conf_ff;
   assign rsp.out_x = out_x_ff;
   assign rsp.out_y = out_y_ff;
   assign rsp.out_width = out_w_ff;
   assign rsp.out_height = out_h_ff;

endmodule
